// File: sv/gbts_pkg.sv
// Shared types and constants for the gap buffer text store.
package gbts_pkg;

    // Default store depth in characters.
    localparam int CAPACITY_DEF = 1024;

    // Fixed field widths of the command and result beats.
    localparam int ACT_W = 2;
    localparam int POS_W = 11;
    localparam int CH_W  = 8;
    localparam int CNT_W = 11;
    localparam int ST_W  = 2;
    localparam int LEN_W = 11;

    // Operation codes.
    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // Result status codes.
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_CLIP  = 2'd3
    } t_status;

    // Command beat.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [CH_W-1:0]  ch;
        logic [CNT_W-1:0] count;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [CH_W-1:0]  read_char;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] char_count;
    } t_out;

endpackage

// File: sv/gap_buffer_text_store.sv
// Gap buffer character store with a sequencer that moves the gap one character at a time.
// Append and refused commands go from S_EVAL to S_DONE, a read passes through S_RDWAIT,
// and insert or delete move the gap through S_MV_RD and S_MV_WR before S_APPLY and S_DONE.
// Each moved character is read from the single store in S_MV_RD and written back in S_MV_WR.
// A new command is accepted in the cycle its predecessor's result beat is strobed.
// Reset empties the text at once (gap spans the whole store); store contents are left as they are.
module gap_buffer_text_store #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  gbts_pkg::t_in   i_in,
    output gbts_pkg::t_out  o_result,
    output logic            o_done
);
    import gbts_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > POS_W) ? PW : POS_W;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MV_RD,
        S_MV_WR,
        S_APPLY,
        S_RDWAIT,
        S_DONE
    } t_state;

    // Sequencer state and held command.
    t_state           r_state, n_state;
    t_action          r_action, n_action;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PW-1:0]    r_gap_start, n_gap_start;
    logic [PW-1:0]    r_gap_end, n_gap_end;
    t_status          r_status, n_status;
    logic [CH_W-1:0]  r_rchar, n_rchar;
    t_out             r_result, n_result;
    logic             r_done, n_done;

    // Character store.
    logic [CH_W-1:0]  r_mem [CAPACITY];
    logic [CH_W-1:0]  r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [CH_W-1:0]  mem_wd;
    logic [AW-1:0]    mem_ra;

    // Derived pointer values.
    logic [PW-1:0]    len_p;
    logic [PW-1:0]    after_p;
    logic [PW-1:0]    gs_dec;
    logic [PW-1:0]    ge_dec;
    logic [CW-1:0]    len_x;
    logic [CW-1:0]    pos_x;
    logic [CW-1:0]    gs_x;
    logic [CW-1:0]    cnt_x;
    logic [CW-1:0]    idx_x;
    logic [CW-1:0]    end_sum;

    assign busy     = (r_state != S_IDLE);
    assign o_result = r_result;
    assign o_done   = r_done;

    // Text length, room after the gap and neighbor addresses.
    always_comb begin
        len_p   = r_gap_start + (CAP_P - r_gap_end);
        after_p = CAP_P - r_gap_end;
        gs_dec  = r_gap_start - PW'(1);
        ge_dec  = r_gap_end - PW'(1);
        len_x   = CW'(len_p);
        pos_x   = CW'(r_pos);
        gs_x    = CW'(r_gap_start);
        cnt_x   = CW'(r_count);
        idx_x   = (pos_x < gs_x) ? pos_x : pos_x + CW'(r_gap_end - r_gap_start);
        end_sum = CW'(r_gap_end) + cnt_x;
    end

    // Next-state logic of the sequencer and the store access controls.
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_pos       = r_pos;
        n_ch        = r_ch;
        n_count     = r_count;
        n_gap_start = r_gap_start;
        n_gap_end   = r_gap_end;
        n_status    = r_status;
        n_rchar     = r_rchar;
        n_result    = r_result;
        n_done      = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_gap_start[AW-1:0];
        mem_wd      = r_ch;
        mem_ra      = r_gap_end[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action = t_action'(i_in.action);
                    n_pos    = i_in.position;
                    n_ch     = i_in.ch;
                    n_count  = i_in.count;
                    n_status = ST_OK;
                    n_rchar  = '0;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                unique case (r_action)
                    ACT_INSERT: begin
                        if (pos_x > len_x) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else if (r_gap_start >= r_gap_end) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_MV_RD;
                        end
                    end
                    ACT_APPEND: begin
                        if (r_gap_start >= r_gap_end) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we      = 1'b1;
                            n_gap_start = r_gap_start + PW'(1);
                        end
                        n_state = S_DONE;
                    end
                    ACT_DELETE: begin
                        if (pos_x > len_x) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_MV_RD;
                        end
                    end
                    ACT_READ: begin
                        if (pos_x >= len_x) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            mem_ra  = idx_x[AW-1:0];
                            n_state = S_RDWAIT;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_MV_RD: begin
                // Fetch the character that crosses the gap next, or stop when it is in place.
                if (gs_x > pos_x) begin
                    mem_ra  = gs_dec[AW-1:0];
                    n_state = S_MV_WR;
                end else if (gs_x < pos_x && r_gap_end != CAP_P) begin
                    mem_ra  = r_gap_end[AW-1:0];
                    n_state = S_MV_WR;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_MV_WR: begin
                // Drop the fetched character on the far side and slide both gap edges.
                mem_we = 1'b1;
                mem_wd = r_rdata;
                if (gs_x > pos_x) begin
                    mem_wa      = ge_dec[AW-1:0];
                    n_gap_start = gs_dec;
                    n_gap_end   = ge_dec;
                end else begin
                    mem_wa      = r_gap_start[AW-1:0];
                    n_gap_start = r_gap_start + PW'(1);
                    n_gap_end   = r_gap_end + PW'(1);
                end
                n_state = S_MV_RD;
            end
            S_APPLY: begin
                if (r_action == ACT_INSERT) begin
                    mem_we      = 1'b1;
                    n_gap_start = r_gap_start + PW'(1);
                end else if (cnt_x > CW'(after_p)) begin
                    n_gap_end = CAP_P;
                    n_status  = ST_CLIP;
                end else begin
                    n_gap_end = PW'(end_sum);
                end
                n_state = S_DONE;
            end
            S_RDWAIT: begin
                n_rchar = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_result.read_char  = r_rchar;
                n_result.status     = r_status;
                n_result.char_count = len_x[LEN_W-1:0];
                n_done              = 1'b1;
                n_state             = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer state and registered result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gap_start <= '0;
            r_gap_end   <= CAP_P;
            r_done      <= 1'b0;
            r_action    <= ACT_INSERT;
            r_status    <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_gap_start <= n_gap_start;
            r_gap_end   <= n_gap_end;
            r_done      <= n_done;
            r_action    <= n_action;
            r_status    <= n_status;
        end
        r_pos    <= n_pos;
        r_ch     <= n_ch;
        r_count  <= n_count;
        r_rchar  <= n_rchar;
        r_result <= n_result;
    end

    // Single-port-write, registered-read character store.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    // The gap never inverts.
    a_gap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap_start <= r_gap_end && r_gap_end <= CAP_P)
        else $error("gap edges out of order");

    // A result beat is strobed only once the sequencer is free again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !busy)
        else $error("result strobed while busy");

    // An accepted command makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start the sequencer");

    // One strobe per command: never two beats back to back.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe lasted more than one cycle");

    // A full refusal only answers an insert or an append.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.status == ST_FULL) |->
            (r_action == ACT_INSERT || r_action == ACT_APPEND))
        else $error("full status on a command that adds nothing");

endmodule

// File: verif/gap_buffer_text_store_tb.sv
// Self-checking testbench for the gap buffer text store, with a behavioral model of the text.
module gap_buffer_text_store_tb;
    import gbts_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 15_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 50;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_done;
    t_in  i_in;
    t_out o_result;

    // Model of the text: store contents and the two gap edges.
    logic [7:0]  text_mem [CAP];
    int unsigned gap_lo;
    int unsigned gap_hi;

    // Results predicted for accepted command beats, oldest first.
    t_out        expected_q [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct    = 0;

    gap_buffer_text_store u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_result (o_result),
        .o_done   (o_done)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The run is ended if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned text_len();
        return gap_lo + (CAP - gap_hi);
    endfunction

    function automatic void clear_text();
        gap_lo = 0;
        gap_hi = CAP;
        foreach (text_mem[k]) text_mem[k] = 8'h00;
    endfunction

    // Moves the gap to a logical offset, one character per step.
    function automatic void slide_gap(int unsigned target);
        while (gap_lo > target && gap_lo > 0 && gap_hi > 0) begin
            gap_lo--;
            gap_hi--;
            text_mem[gap_hi] = text_mem[gap_lo];
        end
        while (gap_lo < target && gap_hi < CAP) begin
            text_mem[gap_lo] = text_mem[gap_hi];
            gap_lo++;
            gap_hi++;
        end
    endfunction

    // Applies one edit to the model text and returns the result beat it should give.
    function automatic t_out apply_edit(t_in cmd);
        int unsigned len;
        int unsigned pos;
        int unsigned cnt;
        int unsigned tail;
        int unsigned idx;
        t_out        res;
        len = text_len();
        pos = 32'(cmd.position);
        cnt = 32'(cmd.count);
        res = '0;
        res.status = ST_OK;
        case (t_action'(cmd.action))
            ACT_INSERT: begin
                if (pos > len) begin
                    res.status = ST_RANGE;
                end else if (gap_lo >= gap_hi) begin
                    res.status = ST_FULL;
                end else begin
                    slide_gap(pos);
                    text_mem[gap_lo] = cmd.ch;
                    gap_lo++;
                end
            end
            ACT_APPEND: begin
                if (gap_lo >= gap_hi) begin
                    res.status = ST_FULL;
                end else begin
                    text_mem[gap_lo] = cmd.ch;
                    gap_lo++;
                end
            end
            ACT_DELETE: begin
                if (pos > len) begin
                    res.status = ST_RANGE;
                end else begin
                    slide_gap(pos);
                    tail = CAP - gap_hi;
                    // A run past the end of the text is cut short.
                    if (cnt > tail) begin
                        cnt = tail;
                        res.status = ST_CLIP;
                    end
                    gap_hi += cnt;
                end
            end
            default: begin
                if (pos >= len) begin
                    res.status = ST_RANGE;
                end else begin
                    idx = (pos < gap_lo) ? pos : pos + (gap_hi - gap_lo);
                    if (idx < CAP) res.read_char = text_mem[idx];
                end
            end
        endcase
        len = text_len();
        res.char_count = len[LEN_W-1:0];
        return res;
    endfunction

    function automatic t_in make_cmd(t_action act, int unsigned pos, logic [7:0] chr,
                                     int unsigned cnt);
        t_in cmd;
        cmd.action   = act;
        cmd.position = pos[POS_W-1:0];
        cmd.ch       = chr;
        cmd.count    = cnt[CNT_W-1:0];
        return cmd;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Drives one command beat, with an optional idle stretch first, and records its prediction.
    task automatic send_cmd(input t_in cmd);
        @(negedge i_clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= cmd;
        do @(posedge i_clk); while (busy);
        expected_q.push_back(apply_edit(cmd));
    endtask

    // Every result beat is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_result
        t_out want;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result beat with no command outstanding");
            end else begin
                want = expected_q.pop_front();
                if (o_result.read_char !== want.read_char)
                    report_mismatch($sformatf("read_char %h, expected %h",
                                              o_result.read_char, want.read_char));
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_result.status, want.status));
                if (o_result.char_count !== want.char_count)
                    report_mismatch($sformatf("char_count %0d, expected %0d",
                                              o_result.char_count, want.char_count));
            end
        end
    end

    // Short edits on an empty and a small text, covering each operation and the range and clip errors.
    task automatic test_directed_edits();
        send_cmd(make_cmd(ACT_READ,   0,    8'h00, 0));
        send_cmd(make_cmd(ACT_DELETE, 0,    8'h00, 0));
        send_cmd(make_cmd(ACT_DELETE, 0,    8'h00, 5));
        send_cmd(make_cmd(ACT_INSERT, 1,    8'h11, 0));
        send_cmd(make_cmd(ACT_INSERT, 0,    8'h00, 0));
        send_cmd(make_cmd(ACT_APPEND, 2047, 8'hFF, 2047));
        send_cmd(make_cmd(ACT_INSERT, 2,    8'hA5, 0));
        send_cmd(make_cmd(ACT_INSERT, 0,    8'h5A, 0));
        send_cmd(make_cmd(ACT_READ,   0,    8'h00, 0));
        send_cmd(make_cmd(ACT_READ,   1,    8'h00, 0));
        send_cmd(make_cmd(ACT_READ,   2,    8'h00, 0));
        send_cmd(make_cmd(ACT_READ,   3,    8'h00, 0));
        send_cmd(make_cmd(ACT_READ,   4,    8'h00, 0));
        send_cmd(make_cmd(ACT_READ,   2047, 8'hFF, 2047));
        send_cmd(make_cmd(ACT_DELETE, 1,    8'h00, 2));
        send_cmd(make_cmd(ACT_INSERT, 2047, 8'hFF, 0));
        send_cmd(make_cmd(ACT_DELETE, 1024, 8'h00, 1));
        send_cmd(make_cmd(ACT_INSERT, 2,    8'h3C, 0));
        send_cmd(make_cmd(ACT_DELETE, 2,    8'h00, 0));
        send_cmd(make_cmd(ACT_DELETE, 1,    8'h00, 2047));
        send_cmd(make_cmd(ACT_READ,   0,    8'h00, 0));
        send_cmd(make_cmd(ACT_DELETE, 0,    8'h00, 1024));
    endtask

    // Fills the store, checks refusals when full, then empties it with long gap moves.
    task automatic test_fill_to_capacity();
        while (text_len() < CAP) begin
            if ($urandom_range(0, 3) == 0)
                send_cmd(make_cmd(ACT_INSERT, gap_lo, 8'($urandom), $urandom_range(0, 2047)));
            else
                send_cmd(make_cmd(ACT_APPEND, $urandom_range(0, 2047), 8'($urandom),
                                  $urandom_range(0, 2047)));
        end
        send_cmd(make_cmd(ACT_APPEND, 0,    8'h77, 0));
        send_cmd(make_cmd(ACT_INSERT, 0,    8'h77, 0));
        send_cmd(make_cmd(ACT_INSERT, 1024, 8'h77, 0));
        send_cmd(make_cmd(ACT_INSERT, 1025, 8'h77, 0));
        send_cmd(make_cmd(ACT_READ,   0,    8'h00, 0));
        send_cmd(make_cmd(ACT_READ,   1023, 8'h00, 0));
        send_cmd(make_cmd(ACT_READ,   1024, 8'h00, 0));
        send_cmd(make_cmd(ACT_DELETE, 1024, 8'h00, 0));
        send_cmd(make_cmd(ACT_DELETE, 512,  8'h00, 2047));
        send_cmd(make_cmd(ACT_READ,   511,  8'h00, 0));
        send_cmd(make_cmd(ACT_DELETE, 0,    8'h00, 512));
    endtask

    // Random edits clustered around the cursor, with some far moves and some noise beats.
    task automatic test_random_edits(input int unsigned n_items);
        t_in         cmd;
        int unsigned len;
        int unsigned pick;
        int unsigned pos;
        int unsigned cnt;
        int unsigned roll;
        int          near;
        for (int i = 0; i < n_items; i++) begin
            len  = text_len();
            pick = $urandom_range(0, 99);
            near = int'(gap_lo) + int'($urandom_range(0, 16)) - 8;
            if (near < 0) near = 0;
            if (near > int'(len)) near = int'(len);
            pos  = near;
            roll = $urandom_range(0, 99);
            if (roll < 8)
                pos = $urandom_range(0, len);
            else if (roll < 11)
                pos = len + $urandom_range(1, 3);
            roll = $urandom_range(0, 99);
            if (roll < 85)
                cnt = $urandom_range(0, 4);
            else if (roll < 95)
                cnt = $urandom_range(0, 64);
            else
                cnt = $urandom_range(0, 2047);
            if (pick < 5)
                cmd = make_cmd(t_action'($urandom_range(0, 3)), $urandom_range(0, 2047),
                               8'($urandom), $urandom_range(0, 2047));
            else if (pick < 33)
                cmd = make_cmd(ACT_INSERT, pos, 8'($urandom), $urandom_range(0, 2047));
            else if (pick < 55)
                cmd = make_cmd(ACT_APPEND, $urandom_range(0, 2047), 8'($urandom), cnt);
            else if (pick < 75)
                cmd = make_cmd(ACT_DELETE, pos, 8'($urandom), cnt);
            else if (pick < 88)
                cmd = make_cmd(ACT_READ, pos, 8'($urandom), cnt);
            else
                cmd = make_cmd(ACT_READ, $urandom_range(0, len), 8'($urandom), cnt);
            send_cmd(cmd);
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_in    = '0;
        clear_text();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 20;
        test_directed_edits();
        idle_pct = 0;
        test_fill_to_capacity();
        idle_pct = 0;
        test_random_edits(170);
        idle_pct = 54;
        test_random_edits(170);
        idle_pct = 20;
        test_random_edits(170);
        idle_pct = 0;
        test_random_edits(140);

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/gbts_pkg.sv
sv/gap_buffer_text_store.sv
verif/gap_buffer_text_store_tb.sv
